[sv/rse_pkg.sv]
// shared constants, codes and types of the rpn stack evaluator
package rse_pkg;

  // sizes
  localparam int STACK_DEPTH    = 128;
  localparam int VARIABLE_COUNT = 26;

  // field widths
  localparam int CMD_W   = 4;
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 5;
  localparam int STAT_W  = 3;
  localparam int DEPTH_W = 8;

  // derived widths
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADR_W = $clog2(STACK_DEPTH);
  localparam int VS_W  = $clog2(VARIABLE_COUNT + 1);
  localparam int VI_W  = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

  // stack and variable limits
  localparam logic [SP_W-1:0]  SP_FULL   = SP_W'(STACK_DEPTH);
  localparam logic [VS_W-1:0]  VS_FULL   = VS_W'(VARIABLE_COUNT);
  localparam logic [IDX_W-1:0] VAR_LIMIT = IDX_W'(VARIABLE_COUNT);

  // divider sizes
  localparam int DVD_W     = 48;
  localparam int DIV_STEPS = DVD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  // commands
  localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
  localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
  localparam logic [CMD_W-1:0] CMD_MUL   = 4'd3;
  localparam logic [CMD_W-1:0] CMD_DIV   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MOD   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_POP   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_STORE = 4'd7;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 4'd8;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZDIV  = 3'd3;
  localparam logic [STAT_W-1:0] ST_VFULL = 3'd4;

  // datapath step codes
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t DP_NOP     = 4'd0;
  localparam dp_op_t DP_LATCH   = 4'd1;
  localparam dp_op_t DP_VFULL   = 4'd2;
  localparam dp_op_t DP_POPB    = 4'd3;
  localparam dp_op_t DP_LOADTOP = 4'd4;
  localparam dp_op_t DP_POPA    = 4'd5;
  localparam dp_op_t DP_EXEC    = 4'd6;
  localparam dp_op_t DP_MULSAT  = 4'd7;
  localparam dp_op_t DP_DIVSAT  = 4'd8;
  localparam dp_op_t DP_PUSH    = 4'd9;
  localparam dp_op_t DP_OUT     = 4'd10;

  // controller to datapath
  typedef struct packed {
    dp_op_t op;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             vars_full;
    logic             zdiv;
    logic             div_done;
  } dp_stat_t;

endpackage

[sv/rse_div.sv]
// restoring divider, one quotient bit per cycle
module rse_div
  import rse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [DVD_W-1:0]  quotient,
  output logic [WORD_W-1:0] remainder
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [WORD_W:0]   rem;
  logic [DVD_W-1:0]  quo;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   shifted;
  logic [WORD_W+1:0] diff;
  logic              ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem[WORD_W-1:0], quo[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~diff[WORD_W+1];
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[WORD_W:0] : shifted;
      quo <= {quo[DVD_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[WORD_W-1:0];

endmodule

[sv/rse_dp.sv]
// datapath: operand stack memory, variables, alu and result register
module rse_dp
  import rse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  dp_ctl_t            ctl,
  output dp_stat_t           stat,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [WORD_W-1:0]  in_value,
  input  logic [IDX_W-1:0]   in_var_index,
  output logic [WORD_W-1:0]  out_value,
  output logic [STAT_W-1:0]  out_status,
  output logic [DEPTH_W-1:0] out_depth
);

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_W-1:0] vars [VARIABLE_COUNT];
  logic [WORD_W-1:0] rd_data;
  logic [SP_W-1:0]   sp;
  logic [VS_W-1:0]   vslot;
  logic [STAT_W-1:0] status;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] tos;
  logic [WORD_W-1:0] opa;
  logic [WORD_W-1:0] opb;
  logic [WORD_W-1:0] res;
  logic signed [2*WORD_W-1:0] prod;

  logic              sp_zero;
  logic              can_push;
  logic              mem_we;
  logic [ADR_W-1:0]  rd_addr;
  logic [WORD_W-1:0] b_pop;
  logic [WORD_W-1:0] abs_bpop;
  logic              zdiv;
  logic [WORD_W-1:0] var_rd;
  logic [WORD_W-1:0] abs_a;
  logic [WORD_W-1:0] abs_b;
  logic signed [2*WORD_W-1:0] prod_sh;
  logic [WORD_W-1:0] mul_sat;
  logic [WORD_W-1:0] div_sat;
  logic [WORD_W-1:0] mod_res;
  logic [WORD_W-1:0] mod_mag;
  logic              q_neg;
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [WORD_W-1:0] div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic [WORD_W-1:0] div_rem;
  logic [WORD_W-1:0] shown;

  // first error of a step wins
  function automatic logic [STAT_W-1:0] flag(input logic [STAT_W-1:0] cur,
                                             input logic [STAT_W-1:0] code);
    flag = (cur == ST_OK) ? code : cur;
  endfunction

  // stack pointer conditions and popped top
  always_comb begin
    sp_zero  = (sp == '0);
    can_push = (sp < SP_FULL);
    mem_we   = (ctl.op == DP_PUSH) && can_push;
    rd_addr  = ADR_W'(sp - SP_W'(2));
    b_pop    = sp_zero ? '0 : tos;
    abs_bpop = b_pop[WORD_W-1] ? WORD_W'(-b_pop) : b_pop;
    zdiv     = ((cmd == CMD_DIV) && (b_pop == '0)) ||
               ((cmd == CMD_MOD) && (abs_bpop[WORD_W-1:16] == '0));
  end

  // variable read for load
  always_comb begin
    var_rd = (in_var_index < VAR_LIMIT) ? vars[in_var_index[VI_W-1:0]] : '0;
  end

  // operand magnitudes and divider operands
  always_comb begin
    abs_a = opa[WORD_W-1] ? WORD_W'(-opa) : opa;
    abs_b = opb[WORD_W-1] ? WORD_W'(-opb) : opb;
    q_neg = opa[WORD_W-1] ^ opb[WORD_W-1];
    if (cmd == CMD_DIV) begin
      div_dvd = {abs_a, 16'd0};
      div_dvs = abs_b;
    end else begin
      div_dvd = DVD_W'(abs_a[WORD_W-1:16]);
      div_dvs = WORD_W'(abs_b[WORD_W-1:16]);
    end
    div_start = (ctl.op == DP_EXEC) && ((cmd == CMD_DIV) || (cmd == CMD_MOD));
  end

  // multiply: floor shift then saturate
  always_comb begin
    prod_sh = prod >>> 16;
    if (prod_sh > 64'sh0000_0000_7FFF_FFFF) begin
      mul_sat = 32'h7FFF_FFFF;
    end else if (prod_sh < -64'sh0000_0000_8000_0000) begin
      mul_sat = 32'h8000_0000;
    end else begin
      mul_sat = prod_sh[WORD_W-1:0];
    end
  end

  // divide saturation and modulo result
  always_comb begin
    if (!q_neg) begin
      div_sat = (div_quo > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[WORD_W-1:0];
    end else begin
      div_sat = (div_quo > DVD_W'(32'h8000_0000)) ? 32'h8000_0000
                                                  : WORD_W'(-div_quo[WORD_W-1:0]);
    end
    mod_mag = {div_rem[15:0], 16'd0};
    mod_res = opa[WORD_W-1] ? WORD_W'(-mod_mag) : mod_mag;
  end

  rse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // operand stack memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[ADR_W'(sp)] <= res;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // control state: pointer, variable slot, variables, status
  always_ff @(posedge clk) begin
    if (rst) begin
      sp     <= '0;
      vslot  <= '0;
      status <= ST_OK;
      for (int i = 0; i < VARIABLE_COUNT; i++) begin
        vars[i] <= '0;
      end
    end else begin
      case (ctl.op)
        DP_LATCH: begin
          status <= ST_OK;
        end
        DP_VFULL: begin
          status <= flag(status, ST_VFULL);
        end
        DP_POPB: begin
          if (sp_zero) begin
            status <= ST_EMPTY;
          end else begin
            sp <= sp - SP_W'(1);
            if (zdiv) begin
              status <= flag(status, ST_ZDIV);
            end
          end
          if (cmd == CMD_STORE) begin
            vars[vslot[VI_W-1:0]] <= b_pop;
            vslot <= vslot + VS_W'(1);
          end
        end
        DP_POPA: begin
          if (sp_zero) begin
            status <= flag(status, ST_EMPTY);
          end else begin
            sp <= sp - SP_W'(1);
          end
        end
        DP_PUSH: begin
          if (can_push) begin
            sp <= sp + SP_W'(1);
          end else begin
            status <= flag(status, ST_FULL);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // shown value of the step
  always_comb begin
    if (cmd == CMD_POP) begin
      shown = opb;
    end else begin
      shown = sp_zero ? '0 : tos;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_LATCH: begin
        cmd <= in_command;
        res <= (in_command == CMD_LOAD) ? var_rd : in_value;
      end
      DP_POPB: begin
        opb <= b_pop;
      end
      DP_LOADTOP: begin
        tos <= rd_data;
      end
      DP_POPA: begin
        opa <= sp_zero ? '0 : rd_data;
      end
      DP_EXEC: begin
        if (cmd == CMD_SUB) begin
          res <= opa - opb;
        end else begin
          res <= opa + opb;
        end
        prod <= $signed(opa) * $signed(opb);
      end
      DP_MULSAT: begin
        res <= mul_sat;
      end
      DP_DIVSAT: begin
        res <= (cmd == CMD_DIV) ? div_sat : mod_res;
      end
      DP_PUSH: begin
        if (can_push) begin
          tos <= res;
        end
      end
      DP_OUT: begin
        out_value  <= shown;
        out_status <= status;
        out_depth  <= DEPTH_W'(sp);
      end
      default: begin
      end
    endcase
  end

  // status toward the controller
  always_comb begin
    stat.cmd       = cmd;
    stat.vars_full = (vslot >= VS_FULL);
    stat.zdiv      = zdiv;
    stat.div_done  = div_done;
  end

endmodule

[sv/rse_ctrl.sv]
// controller: sequences one token through the datapath steps
module rse_ctrl
  import rse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_ctl_t  ctl
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_POPB    = 4'd2;
  localparam logic [3:0] S_LOADTOP = 4'd3;
  localparam logic [3:0] S_POPA    = 4'd4;
  localparam logic [3:0] S_EXEC    = 4'd5;
  localparam logic [3:0] S_MULSAT  = 4'd6;
  localparam logic [3:0] S_DIVW    = 4'd7;
  localparam logic [3:0] S_DIVSAT  = 4'd8;
  localparam logic [3:0] S_PUSH    = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_load;
  logic       binary_op;

  assign binary_op = (stat.cmd == CMD_ADD) || (stat.cmd == CMD_SUB) ||
                     (stat.cmd == CMD_MUL) || (stat.cmd == CMD_DIV) ||
                     (stat.cmd == CMD_MOD);

  // next state and datapath step
  always_comb begin
    state_next = state;
    ctl.op     = DP_NOP;
    out_load   = 1'b0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = DP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if ((stat.cmd == CMD_PUSH) || (stat.cmd == CMD_LOAD)) begin
          state_next = S_PUSH;
        end else if (binary_op || (stat.cmd == CMD_POP)) begin
          state_next = S_POPB;
        end else if (stat.cmd == CMD_STORE) begin
          if (stat.vars_full) begin
            ctl.op     = DP_VFULL;
            state_next = S_DONE;
          end else begin
            state_next = S_POPB;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_POPB: begin
        ctl.op = DP_POPB;
        if (binary_op && !stat.zdiv) begin
          state_next = S_POPA;
        end else begin
          state_next = S_LOADTOP;
        end
      end
      S_LOADTOP: begin
        ctl.op     = DP_LOADTOP;
        state_next = S_DONE;
      end
      S_POPA: begin
        ctl.op     = DP_POPA;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        ctl.op = DP_EXEC;
        if (stat.cmd == CMD_MUL) begin
          state_next = S_MULSAT;
        end else if ((stat.cmd == CMD_DIV) || (stat.cmd == CMD_MOD)) begin
          state_next = S_DIVW;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_MULSAT: begin
        ctl.op     = DP_MULSAT;
        state_next = S_PUSH;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_next = S_DIVSAT;
        end
      end
      S_DIVSAT: begin
        ctl.op     = DP_DIVSAT;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        ctl.op     = DP_PUSH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.op     = DP_OUT;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/rpn_stack_evaluator.sv]
// top level of the rpn stack calculator on signed q16.16 tokens
//
//   channel | dir | tdata fields, lowest bit first
//   s_axis  | in  | command[3:0] value[35:4] var_index[40:36] zeros[47:41]
//   m_axis  | out | result_value[31:0] status[34:32] depth[42:35] zeros[47:43]
//
// one token at a time: a new token is taken only once the last one is through;
// div and mod take longest, as they wait on the 48-step restoring divider.
// a finished beat waits in the output register while the next token is taken.
// reset clears the stack pointer, the variable slot and all variables; the
// stack memory is not cleared, only written entries are ever read.
module rpn_stack_evaluator
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // command[3:0], value[35:4], var_index[40:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // result_value[31:0], status[34:32], depth[42:35]
);

  dp_ctl_t            ctl;
  dp_stat_t           stat;
  logic [WORD_W-1:0]  out_value;
  logic [STAT_W-1:0]  out_status;
  logic [DEPTH_W-1:0] out_depth;

  // sequencer
  rse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // stack, variables and arithmetic
  rse_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .in_command   (s_tdata[3:0]),
    .in_value     (s_tdata[35:4]),
    .in_var_index (s_tdata[40:36]),
    .out_value    (out_value),
    .out_status   (out_status),
    .out_depth    (out_depth)
  );

  // output beat packing
  assign m_tdata = {5'd0, out_depth, out_status, out_value};

endmodule

[tb/rpn_stack_evaluator_test.sv]
// self-checking testbench of the rpn stack evaluator against a q16.16 token predictor
module rpn_stack_evaluator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rse_pkg::*;

  // run limits
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 80;

  // commands with no meaning, which must leave everything alone
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_LOAD + 4'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;

  // saturation bounds of q16.16
  localparam longint Q16_MAX = 2147483647;
  localparam longint Q16_MIN = -Q16_MAX - 1;

  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [STAT_W-1:0]  status;
    logic [DEPTH_W-1:0] depth;
  } calc_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // command[3:0], value[35:4], var_index[40:36]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // result_value[31:0], status[34:32], depth[42:35]

  // predictor state
  logic [WORD_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_sp;
  logic [WORD_W-1:0] calc_vars [VARIABLE_COUNT];
  int unsigned       calc_vslot;
  logic [STAT_W-1:0] calc_status;

  calc_result_t pending_results [$];
  int           error_count  = 0;
  int           quiet_cycles = 0;
  bit           gaps_on      = 1'b1;

  rpn_stack_evaluator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  always #5 clk = ~clk;

  // first error of a token is the one reported
  function automatic void raise_status(input logic [STAT_W-1:0] code);
    if (calc_status == ST_OK) calc_status = code;
  endfunction

  // an empty pop reads as zero
  function automatic logic [WORD_W-1:0] pop_operand();
    if (calc_sp > 0) begin
      calc_sp--;
      return calc_stack[calc_sp];
    end
    raise_status(ST_EMPTY);
    return '0;
  endfunction

  // a push onto a full stack is dropped
  function automatic void push_operand(input logic [WORD_W-1:0] v);
    if (calc_sp < STACK_DEPTH) begin
      calc_stack[calc_sp] = v;
      calc_sp++;
    end else begin
      raise_status(ST_FULL);
    end
  endfunction

  function automatic logic [WORD_W-1:0] clamp_q16(input longint x);
    if (x > Q16_MAX) return WORD_W'(Q16_MAX);
    if (x < Q16_MIN) return WORD_W'(Q16_MIN);
    return WORD_W'(x);
  endfunction

  // work out the result beat of one accepted token
  task automatic predict_token(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                               input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] lhs;
    logic [WORD_W-1:0] rhs;
    logic [WORD_W-1:0] shown;
    longint            a;
    longint            b;
    bit                popped_shown;
    calc_result_t      res;
    calc_status  = ST_OK;
    popped_shown = 1'b0;
    shown        = '0;
    case (cmd)
      CMD_PUSH: push_operand(val);
      CMD_ADD: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(lhs + rhs);
      end
      CMD_SUB: begin
        rhs = pop_operand();
        lhs = pop_operand();
        push_operand(lhs - rhs);
      end
      CMD_MUL: begin
        // arithmetic shift floors the product
        b = $signed(pop_operand());
        a = $signed(pop_operand());
        push_operand(clamp_q16((a * b) >>> 16));
      end
      CMD_DIV: begin
        b = $signed(pop_operand());
        if (b == 0) begin
          raise_status(ST_ZDIV);
        end else begin
          a = $signed(pop_operand());
          push_operand(clamp_q16((a * 65536) / b));
        end
      end
      CMD_MOD: begin
        // integer parts truncated toward zero, remainder follows the dividend
        b = $signed(pop_operand());
        b = b / 65536;
        if (b == 0) begin
          raise_status(ST_ZDIV);
        end else begin
          a = $signed(pop_operand());
          a = a / 65536;
          push_operand(WORD_W'((a % b) * 65536));
        end
      end
      CMD_POP: begin
        shown        = pop_operand();
        popped_shown = 1'b1;
      end
      CMD_STORE: begin
        if (calc_vslot >= VARIABLE_COUNT) begin
          raise_status(ST_VFULL);
        end else begin
          calc_vars[calc_vslot] = pop_operand();
          calc_vslot++;
        end
      end
      CMD_LOAD: push_operand((idx < VARIABLE_COUNT) ? calc_vars[idx] : '0);
      default: ;
    endcase
    if (!popped_shown) shown = (calc_sp > 0) ? calc_stack[calc_sp-1] : '0;
    res.value  = shown;
    res.status = calc_status;
    res.depth  = DEPTH_W'(calc_sp);
    pending_results.push_back(res);
  endtask

  // send one token beat and predict it once accepted
  task automatic send_token(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                            input logic [IDX_W-1:0] idx);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, idx, val, cmd};
    do @(posedge clk); while (!s_tready);
    predict_token(cmd, val, idx);
  endtask

  // hold the input until every result beat is back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // mix of extremes, small and full-range integers, fractions and raw words
  function automatic logic [WORD_W-1:0] random_q16();
    int k;
    case ($urandom_range(0, 5))
      0: return WORD_W'($urandom());
      1: begin
        k = int'($urandom_range(0, 40)) - 20;
        return WORD_W'(k * 65536);
      end
      2: begin
        k = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) != 0) k = -k;
        return WORD_W'(k);
      end
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      4: begin
        k = int'($urandom_range(0, 65535)) - 32768;
        return WORD_W'(k * 65536);
      end
      default: return WORD_W'($urandom());
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] random_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_PUSH;
    if (r < 38) return CMD_LOAD;
    if (r < 48) return CMD_ADD;
    if (r < 58) return CMD_SUB;
    if (r < 68) return CMD_MUL;
    if (r < 76) return CMD_DIV;
    if (r < 84) return CMD_MOD;
    if (r < 92) return CMD_POP;
    if (r < 96) return CMD_STORE;
    return CMD_SPARE_LO + CMD_W'($urandom_range(0, 6));
  endfunction

  task automatic drain_stack();
    while (calc_sp > 0) send_token(CMD_POP, random_q16(), IDX_W'($urandom_range(0, 31)));
  endtask

  // push extremes, show them, then show from an empty stack
  task automatic test_push_and_show();
    send_token(CMD_PUSH, 32'h7fff_ffff, '0);
    send_token(CMD_PUSH, 32'h8000_0000, '1);
    send_token(CMD_POP, '0, '0);
    send_token(CMD_POP, '1, '0);
    send_token(CMD_POP, '0, '0);
  endtask

  // wrapping add, sub, saturating and flooring mul, empty operands
  task automatic test_arithmetic();
    send_token(CMD_PUSH, 32'h7fff_ffff, '0);
    send_token(CMD_PUSH, 32'h0000_0001, '0);
    send_token(CMD_ADD, '0, '0);
    send_token(CMD_PUSH, 32'h0002_0000, '0);
    send_token(CMD_MUL, '0, '0);
    send_token(CMD_PUSH, 32'hffff_8000, '0);
    send_token(CMD_PUSH, 32'h0000_0001, '0);
    send_token(CMD_MUL, '0, '0);
    send_token(CMD_SUB, '0, '0);
    drain_stack();
    send_token(CMD_ADD, '0, '0);
    send_token(CMD_MUL, '0, '0);
    drain_stack();
  endtask

  // divide saturation, zero divisors and signed remainder
  task automatic test_divide_and_mod();
    send_token(CMD_PUSH, 32'h7fff_ffff, '0);
    send_token(CMD_PUSH, 32'h0000_0001, '0);
    send_token(CMD_DIV, '0, '0);
    send_token(CMD_PUSH, 32'h0000_0000, '0);
    send_token(CMD_DIV, '0, '0);
    send_token(CMD_PUSH, 32'h0000_8000, '0);
    send_token(CMD_MOD, '0, '0);
    send_token(CMD_PUSH, 32'hfff9_0000, '0);
    send_token(CMD_PUSH, 32'h0002_0000, '0);
    send_token(CMD_MOD, '0, '0);
    send_token(CMD_DIV, '0, '0);
    drain_stack();
    send_token(CMD_DIV, '0, '0);
  endtask

  // store, store from empty, loads in and out of range, spare commands
  task automatic test_variables();
    send_token(CMD_PUSH, 32'h0003_0000, '0);
    send_token(CMD_STORE, '0, '0);
    send_token(CMD_STORE, '0, '0);
    send_token(CMD_LOAD, '0, IDX_W'(0));
    send_token(CMD_LOAD, '0, '1);
    send_token(CMD_SPARE_LO, '1, '1);
    send_token(CMD_SPARE_HI, '0, '0);
    drain_stack();
  endtask

  // random tokens, kept mostly well formed by feeding a shallow stack
  task automatic test_random_tokens(input int count);
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (calc_sp < 2 && $urandom_range(0, 7) != 0)
        cmd = ($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_PUSH;
      else
        cmd = random_command();
      send_token(cmd, random_q16(), IDX_W'($urandom_range(0, 31)));
    end
    gaps_on = 1'b1;
  endtask

  // fill the stack, push past the top, work near the top, then empty it and pop from empty
  task automatic test_stack_overflow();
    while (calc_sp < STACK_DEPTH)
      send_token(($urandom_range(0, 5) == 0) ? CMD_LOAD : CMD_PUSH, random_q16(),
                 IDX_W'($urandom_range(0, 31)));
    send_token(CMD_PUSH, random_q16(), '0);
    send_token(CMD_LOAD, '0, IDX_W'(0));
    repeat (80)
      send_token(($urandom_range(0, 1) != 0) ? CMD_PUSH : random_command(), random_q16(),
                 IDX_W'($urandom_range(0, 31)));
    drain_stack();
    send_token(CMD_POP, '0, '0);
  endtask

  // result side: random stalls, then compare each beat with the oldest prediction
  initial begin : result_checker
    int           stall;
    calc_result_t got;
    calc_result_t want;
    do @(posedge clk); while (rst);
    forever begin
      stall = gaps_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.value  = m_tdata[31:0];
      got.status = m_tdata[34:32];
      got.depth  = m_tdata[42:35];
      if (pending_results.size() == 0) begin
        $error("result beat with no token waiting: value %h status %0d depth %0d",
               got.value, got.status, got.depth);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.value !== want.value) begin
          $error("result_value: expected %h, got %h", want.value, got.value);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status field: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, got.depth);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // reset, predictor init and the test sequence
  initial begin
    calc_sp    = 0;
    calc_vslot = 0;
    foreach (calc_vars[i]) calc_vars[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_push_and_show();
    test_arithmetic();
    test_divide_and_mod();
    test_variables();
    test_random_tokens(900);
    wait_results_done();
    test_stack_overflow();
    test_random_tokens(450);
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
